>>> hdl/lcse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcse_pkg;

  localparam int SCRIPT_DEPTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // opcode register reset values
  localparam logic [7:0] OP_GO_RESET    = 8'd110;
  localparam logic [7:0] OP_FADE_RESET  = 8'd99;
  localparam logic [7:0] OP_WRITE_RESET = 8'd87;
  localparam logic [7:0] OP_PLAY_RESET  = 8'd112;
  localparam logic [7:0] OP_STOP_RESET  = 8'd111;
  localparam logic [7:0] OP_BOOT_RESET  = 8'd66;

  // configuration register indexes
  localparam logic [2:0] REG_GO    = 3'd0;
  localparam logic [2:0] REG_FADE  = 3'd1;
  localparam logic [2:0] REG_WRITE = 3'd2;
  localparam logic [2:0] REG_PLAY  = 3'd3;
  localparam logic [2:0] REG_STOP  = 3'd4;
  localparam logic [2:0] REG_BOOT  = 3'd5;

  // result action codes
  localparam logic [1:0] ACT_GO   = 2'd0;
  localparam logic [1:0] ACT_FADE = 2'd1;
  localparam logic [1:0] ACT_BOOT = 2'd2;

  typedef enum logic [2:0] {
    CLS_GO, CLS_FADE, CLS_WRITE, CLS_PLAY, CLS_STOP, CLS_BOOT, CLS_NONE
  } cls_t;

  typedef struct packed {
    logic [7:0] go;
    logic [7:0] fade;
    logic [7:0] write_line;
    logic [7:0] play;
    logic [7:0] stop;
    logic [7:0] boot;
  } opcodes_t;

  // one script line: byte 0 (opcode) in the low bits
  typedef logic [31:0] line_t;

  // queue entry: a tick, or a complete frame (opcode class + bytes 1..7)
  typedef struct packed {
    logic            is_tick;
    cls_t            cls;
    logic [6:0][7:0] args;
  } q_entry_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] boot_mode;
  } res_t;

  // first match wins: go, fade, write line, play, stop, boot mode
  function automatic cls_t classify(opcodes_t ops, logic [7:0] b);
    cls_t c;
    if (b == ops.go)              c = CLS_GO;
    else if (b == ops.fade)       c = CLS_FADE;
    else if (b == ops.write_line) c = CLS_WRITE;
    else if (b == ops.play)       c = CLS_PLAY;
    else if (b == ops.stop)       c = CLS_STOP;
    else if (b == ops.boot)       c = CLS_BOOT;
    else                          c = CLS_NONE;
    return c;
  endfunction

  function automatic logic [3:0] frame_len(cls_t c);
    logic [3:0] n;
    case (c)
      CLS_GO:    n = 4'd4;
      CLS_FADE:  n = 4'd4;
      CLS_WRITE: n = 4'd8;
      CLS_PLAY:  n = 4'd4;
      CLS_STOP:  n = 4'd1;
      CLS_BOOT:  n = 4'd6;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/lcse_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcse_front
  import lcse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire opcodes_t ops,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     command,
  input  wire logic [7:0] data_byte,
  input  wire logic     q_full,
  output logic          push,
  output q_entry_t      entry
);

  logic [2:0]      frame_count, frame_count_next;
  logic [3:0]      frame_length, frame_length_next;
  cls_t            cur_cls, cur_cls_next;
  logic [6:0][7:0] args_buf, args_buf_next;
  logic [6:0][7:0] args_merged;
  cls_t            first_cls;
  logic            accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign first_cls = classify(ops, data_byte);

  always_comb begin
    args_merged = args_buf;
    if (frame_count != 3'd0) begin
      args_merged[frame_count - 3'd1] = data_byte;
    end
  end

  always_comb begin
    push              = 1'b0;
    entry.is_tick     = command;
    entry.cls         = cur_cls;
    entry.args        = args_merged;
    frame_count_next  = frame_count;
    frame_length_next = frame_length;
    cur_cls_next      = cur_cls;
    args_buf_next     = args_buf;
    if (accept) begin
      if (command) begin
        push = 1'b1;
      end else if (frame_count == 3'd0) begin
        // unknown opcode is dropped
        if (first_cls != CLS_NONE) begin
          cur_cls_next = first_cls;
          if (frame_len(first_cls) == 4'd1) begin
            push      = 1'b1;
            entry.cls = first_cls;
          end else begin
            frame_count_next  = 3'd1;
            frame_length_next = frame_len(first_cls);
          end
        end
      end else begin
        args_buf_next = args_merged;
        if ({1'b0, frame_count} + 4'd1 >= frame_length) begin
          push             = 1'b1;
          frame_count_next = 3'd0;
        end else begin
          frame_count_next = frame_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= 3'd0;
      frame_length <= 4'd0;
      cur_cls      <= CLS_NONE;
    end else begin
      frame_count  <= frame_count_next;
      frame_length <= frame_length_next;
      cur_cls      <= cur_cls_next;
    end
  end

  always_ff @(posedge clk) begin
    args_buf <= args_buf_next;
  end

endmodule

`default_nettype wire

>>> hdl/lcse_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lcse_queue
  import lcse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t entry_in,
  output logic          full,
  input  wire logic     pop,
  output logic          valid,
  output q_entry_t      entry_out
);

  q_entry_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full      = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid     = (count != '0);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry_in;
  end

endmodule

`default_nettype wire

>>> hdl/lcse_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcse_back
  import lcse_pkg::*;
#(
  parameter int SCRIPT_DEPTH = SCRIPT_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire opcodes_t ops,
  input  wire logic     q_valid,
  input  wire q_entry_t entry,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output res_t          out_res
);

  localparam int AW = $clog2(SCRIPT_DEPTH);

  // script store; reads prefetch the line at the next play position
  line_t             mem [SCRIPT_DEPTH];
  logic [SCRIPT_DEPTH-1:0] line_written;
  line_t             line_data;
  logic              line_valid;
  line_t             line;

  logic              playing, playing_next;
  logic [AW-1:0]     play_position, play_position_next;
  logic [AW-1:0]     last_line, last_line_next;
  logic [7:0]        repeat_target, repeat_target_next;
  logic [7:0]        repeat_done, repeat_done_next;

  cls_t              ex_cls;
  logic [7:0]        b1, b2, b3;
  logic              active;
  logic [AW:0]       pp_work;
  logic [AW-1:0]     start;
  logic              we;
  logic [AW-1:0]     waddr;
  line_t             wdata;
  logic              emit;
  res_t              res_next;

  assign line  = line_valid ? line_data : '0;
  assign q_pop = q_valid && (!out_valid || out_ready);
  assign waddr = entry.args[1][AW-1:0];
  assign wdata = {entry.args[6], entry.args[5], entry.args[4], entry.args[3]};
  assign start = (b3 > 8'(last_line)) ? '0 : b3[AW-1:0];

  always_comb begin
    if (entry.is_tick) begin
      ex_cls = classify(ops, line[7:0]);
      b1     = line[15:8];
      b2     = line[23:16];
      b3     = line[31:24];
      active = playing;
    end else begin
      ex_cls = entry.cls;
      b1     = entry.args[0];
      b2     = entry.args[1];
      b3     = entry.args[2];
      active = 1'b1;
    end
  end

  always_comb begin
    playing_next       = playing;
    play_position_next = play_position;
    last_line_next     = last_line;
    repeat_target_next = repeat_target;
    repeat_done_next   = repeat_done;
    we                 = 1'b0;
    emit               = 1'b0;
    res_next           = out_res;
    pp_work            = {1'b0, play_position} + (AW+1)'(1);
    if (q_pop && active) begin
      case (ex_cls)
        CLS_GO: begin
          emit     = 1'b1;
          res_next = '{action: ACT_GO, red: b1, green: b2, blue: b3, boot_mode: 8'd0};
        end
        CLS_FADE: begin
          emit     = 1'b1;
          res_next = '{action: ACT_FADE, red: b1, green: b2, blue: b3, boot_mode: 8'd0};
        end
        CLS_WRITE: begin
          // stored lines are too short to carry a write
          if (!entry.is_tick && ({1'b0, entry.args[1]} < 9'(SCRIPT_DEPTH))) begin
            we = 1'b1;
            if (waddr > last_line) last_line_next = waddr;
          end
        end
        CLS_PLAY: begin
          repeat_target_next = b2;
          playing_next       = 1'b1;
          if (entry.is_tick) pp_work = {1'b0, start};
          else               play_position_next = start;
        end
        CLS_STOP: begin
          playing_next = 1'b0;
        end
        CLS_BOOT: begin
          emit     = 1'b1;
          res_next = '{action: ACT_BOOT, red: 8'd0, green: 8'd0, blue: 8'd0, boot_mode: b1};
        end
        default: ;
      endcase
      // end of pass: wrap and count repeats
      if (entry.is_tick) begin
        if (pp_work > {1'b0, last_line}) begin
          play_position_next = '0;
          repeat_done_next   = repeat_done + 8'd1;
          if (repeat_target_next != 8'd0 && repeat_done_next >= repeat_target_next) begin
            playing_next     = 1'b0;
            repeat_done_next = 8'd0;
          end
        end else begin
          play_position_next = pp_work[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      play_position <= '0;
      last_line     <= '0;
      repeat_target <= 8'd0;
      repeat_done   <= 8'd0;
      line_written  <= '0;
      line_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      playing       <= playing_next;
      play_position <= play_position_next;
      last_line     <= last_line_next;
      repeat_target <= repeat_target_next;
      repeat_done   <= repeat_done_next;
      if (we) line_written[waddr] <= 1'b1;
      line_valid    <= (we && waddr == play_position_next) || line_written[play_position_next];
      if (q_pop)          out_valid <= emit;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // store write with write-through to the prefetch register
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (we && waddr == play_position_next) line_data <= wdata;
    else                                   line_data <= mem[play_position_next];
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_res <= res_next;
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    play_position <= last_line)
    else $error("play position past last line");

  a_boot_no_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.action == ACT_BOOT |->
      out_res.red == 8'd0 && out_res.green == 8'd0 && out_res.blue == 8'd0)
    else $error("boot mode result carries colour");

  a_tick_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop && entry.is_tick && !playing |=> !out_valid && !playing)
    else $error("tick while stopped had an effect");

endmodule

`default_nettype wire

>>> hdl/led_command_script_engine.sv
// LED command script engine.
// Input channel (in_valid/in_ready): each item is a received command byte
// (command = 0, data_byte) or a playback tick (command = 1). Bytes are
// assembled into frames whose length is set by the opcode in the first byte;
// a complete frame is executed. Ticks run the next stored script line while
// playback is on.
// Output channel (out_valid/out_ready): zero or one result per item, a colour
// action (set or fade) or a boot mode store request.
// Config port: cfg_wr_en writes cfg_data into opcode register cfg_index
// (0 go, 1 fade, 2 write line, 3 play, 4 stop, 5 boot mode); write only while
// idle. Indexes 6 and 7 are ignored.
// Timing: one item per cycle while in_ready is high. The front end registers
// each finished frame or tick into a two-entry queue; the back end executes
// one entry per cycle while the output register is free, and registers the
// result. The next script line is prefetched from the store each cycle.
// Stalls: a full output register holds the back end; the queue absorbs two
// entries, then in_ready drops. Reset clears opcodes to defaults, frame
// assembly, playback state and the script store (per-line valid bits).
`timescale 1ns / 1ps
`default_nettype none

module led_command_script_engine
  import lcse_pkg::*;
#(
  parameter int SCRIPT_DEPTH = SCRIPT_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      action,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic [7:0]      boot_mode,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  opcodes_t ops;
  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_in, q_out;
  res_t     res;

  // opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ops.go         <= OP_GO_RESET;
      ops.fade       <= OP_FADE_RESET;
      ops.write_line <= OP_WRITE_RESET;
      ops.play       <= OP_PLAY_RESET;
      ops.stop       <= OP_STOP_RESET;
      ops.boot       <= OP_BOOT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GO:    ops.go         <= cfg_data;
        REG_FADE:  ops.fade       <= cfg_data;
        REG_WRITE: ops.write_line <= cfg_data;
        REG_PLAY:  ops.play       <= cfg_data;
        REG_STOP:  ops.stop       <= cfg_data;
        REG_BOOT:  ops.boot       <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: frame assembly and opcode classification
  lcse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ops       (ops),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (q_push),
    .entry     (q_in)
  );

  lcse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .entry_out (q_out)
  );

  // back: execution, script store, playback, result register
  lcse_back #(
    .SCRIPT_DEPTH (SCRIPT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ops       (ops),
    .q_valid   (q_valid),
    .entry     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign action    = res.action;
  assign red       = res.red;
  assign green     = res.green;
  assign blue      = res.blue;
  assign boot_mode = res.boot_mode;

endmodule

`default_nettype wire

>>> bench/led_command_script_engine_test.sv
`timescale 1ns / 1ps

module led_command_script_engine_test
  import lcse_pkg::*;
();

  localparam int DEPTH        = 16;  // script lines in the block under test
  localparam int RANDOM_ITEMS = 300; // random items per opcode setting
  localparam int DRAIN_CYCLES = 8;   // drain for the 2-entry queue and the result register

  // one item on the input channel: a received byte or a playback tick
  typedef struct packed {
    logic       tick;
    logic [7:0] data;
  } link_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] boot_mode;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = REG_GO;
  logic [7:0] cfg_data = 8'h00;

  led_command_script_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .boot_mode (boot_mode),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Engine predictor state. opc mirrors the opcode registers; the rest
  // mirrors frame assembly, the script store and playback.
  // ---------------------------------------------------------------------
  logic [7:0]       opc [6];
  logic [7:0][7:0]  frm;            // frm[i] is byte i of the frame being built
  int               frm_cnt;
  int               frm_len;
  bit               playing;
  logic [3:0][7:0]  script [DEPTH]; // byte 0 (opcode) in the low bits
  int               last_ln;
  int               play_pos;
  logic [7:0]       rpt_target;
  logic [7:0]       rpt_done;

  res_t             led_actions_due[$]; // predicted results, oldest first
  link_item_t       link_items[$];      // items waiting for the driver
  int               items_sent = 0;
  int               items_taken = 0;
  int               mismatches = 0;

  int               in_hold = 0;
  int               out_hold = 0;
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // first match wins: go, fade, write line, play, stop, boot mode
  function automatic cls_t decode_op(input logic [7:0] b);
    cls_t c;
    if (b == opc[REG_GO])         c = CLS_GO;
    else if (b == opc[REG_FADE])  c = CLS_FADE;
    else if (b == opc[REG_WRITE]) c = CLS_WRITE;
    else if (b == opc[REG_PLAY])  c = CLS_PLAY;
    else if (b == opc[REG_STOP])  c = CLS_STOP;
    else if (b == opc[REG_BOOT])  c = CLS_BOOT;
    else                          c = CLS_NONE;
    return c;
  endfunction

  function automatic int frame_size(input cls_t c);
    int n;
    case (c)
      CLS_GO, CLS_FADE, CLS_PLAY: n = 4;
      CLS_WRITE:                  n = 8;
      CLS_STOP:                   n = 1;
      CLS_BOOT:                   n = 6;
      default:                    n = 0;
    endcase
    return n;
  endfunction

  // Execute a received frame (full) or a stored line (four bytes only, so a
  // stored write line does nothing).
  task automatic run_line(input logic [7:0][7:0] b, input bit full);
    cls_t c;
    res_t r;
    int   idx;
    c = decode_op(b[0]);
    r = '0;
    case (c)
      CLS_GO, CLS_FADE: begin
        r.action = (c == CLS_GO) ? ACT_GO : ACT_FADE;
        r.red    = b[1];
        r.green  = b[2];
        r.blue   = b[3];
        led_actions_due.push_back(r);
      end
      CLS_WRITE: begin
        // index beyond the store: whole frame ignored
        if (full && b[2] < DEPTH) begin
          idx = int'(b[2]);
          script[idx] = b[7:4];
          if (idx > last_ln) last_ln = idx;
        end
      end
      CLS_PLAY: begin
        rpt_target = b[2];
        play_pos   = (b[3] > last_ln) ? 0 : int'(b[3]);
        playing    = 1'b1;
      end
      CLS_STOP: playing = 1'b0;
      CLS_BOOT: begin
        r.action    = ACT_BOOT;
        r.boot_mode = b[1];
        led_actions_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic predict_led_action(input logic tick, input logic [7:0] data);
    cls_t c;
    int   pos;
    bit   drop;
    if (!tick) begin
      drop = 1'b0;
      if (frm_cnt == 0) begin
        c = decode_op(data);
        if (c == CLS_NONE) drop = 1'b1;  // unknown first byte
        else frm_len = frame_size(c);
      end
      if (!drop) begin
        frm[frm_cnt] = data;
        if (frm_cnt + 1 >= frm_len) begin
          frm_cnt = 0;
          run_line(frm, 1'b1);
        end else begin
          frm_cnt = frm_cnt + 1;
        end
      end
    end else if (playing) begin
      // advance, run the line, then wrap and count the pass
      pos = (play_pos < DEPTH) ? play_pos : 0;
      play_pos = pos + 1;
      run_line({32'h0, script[pos]}, 1'b0);
      if (play_pos > last_ln) begin
        play_pos = 0;
        rpt_done = rpt_done + 8'd1;
        if (rpt_target != 0 && rpt_done >= rpt_target) begin
          playing  = 1'b0;
          rpt_done = 8'd0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued items, predicts each one as it is taken, and
  // draws a random idle gap after every item (none in calm stretches).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : item_drive
    link_item_t it;
    bit         taken;
    if (rst) begin
      in_valid <= 1'b0;
      in_hold  <= 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        predict_led_action(command, data_byte);
        items_taken++;
      end
      if (!in_valid || taken) begin
        if (in_hold > 0) begin
          in_valid <= 1'b0;
          in_hold  <= in_hold - 1;
        end else if (link_items.size() != 0) begin
          it = link_items.pop_front();
          in_valid  <= 1'b1;
          command   <= it.tick;
          data_byte <= it.data;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_hold <= in_calm ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction and
  // holds out_ready low for a random stretch after each one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t want;
    int   stall;
    if (rst) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else begin
      stall = out_hold;
      if (out_valid && out_ready) begin
        if (led_actions_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: action %0d rgb %0d/%0d/%0d mode %0d",
                                    action, red, green, blue, boot_mode));
        end else begin
          want = led_actions_due.pop_front();
          if (action !== want.action)
            report_mismatch($sformatf("action got %0d want %0d", action, want.action));
          if (red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", red, want.red));
          if (green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", green, want.green));
          if (blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", blue, want.blue));
          if (boot_mode !== want.boot_mode)
            report_mismatch($sformatf("boot_mode got %0d want %0d", boot_mode, want.boot_mode));
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        stall = out_calm ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        out_hold  <= stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_hold  <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_item(input logic tick, input logic [7:0] data);
    link_item_t it;
    it.tick = tick;
    it.data = data;
    link_items.push_back(it);
    items_sent++;
  endtask

  // frame byte, now and then preceded by a tick (ticks do not disturb a frame)
  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) push_item(1'b1, 8'($urandom_range(0, 255)));
    push_item(1'b0, b);
  endtask

  task automatic write_opcode(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    opc[idx] = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, tick bursts to run the
  // script, and some noise: stray bytes and truncated frames.
  task automatic random_sequence();
    int         pick;
    int         k;
    logic [7:0] lop;
    logic [7:0] a2;
    logic [7:0] a3;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      frame_byte(pick < 6 ? opc[REG_GO] : opc[REG_FADE]);
      repeat (3) frame_byte(8'($urandom_range(0, 255)));
    end else if (pick < 17) begin
      frame_byte(opc[REG_BOOT]);
      repeat (5) frame_byte(8'($urandom_range(0, 255)));
    end else if (pick < 37) begin
      // write line: pick what the stored line will do when played
      k = $urandom_range(0, 9);
      case (k)
        0, 1, 2, 3: lop = opc[REG_GO];
        4, 5:       lop = opc[REG_FADE];
        6:          lop = opc[REG_BOOT];
        7:          lop = opc[REG_PLAY];
        8:          lop = opc[REG_STOP];
        default:    lop = $urandom_range(0, 1) ? opc[REG_WRITE] : 8'($urandom_range(0, 255));
      endcase
      a2 = (k == 7) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      a3 = (k == 7) ? 8'($urandom_range(0, 17)) : 8'($urandom_range(0, 255));
      frame_byte(opc[REG_WRITE]);
      frame_byte(8'($urandom_range(0, 255)));
      frame_byte($urandom_range(0, 9) == 0 ? 8'($urandom_range(16, 255))
                                           : 8'($urandom_range(0, 15)));
      frame_byte(8'($urandom_range(0, 255)));
      frame_byte(lop);
      frame_byte(8'($urandom_range(0, 255)));
      frame_byte(a2);
      frame_byte(a3);
    end else if (pick < 47) begin
      // play: small repeat targets (0 = forever), start line past the end at times
      frame_byte(opc[REG_PLAY]);
      frame_byte(8'($urandom_range(0, 255)));
      frame_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 4)));
      frame_byte($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 16)));
    end else if (pick < 52) begin
      frame_byte(opc[REG_STOP]);
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 12)) push_item(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      k = $urandom_range(0, 2);
      if (k == 0) begin
        push_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (k == 1) begin
        // truncated frame: the next bytes finish it
        push_item(1'b0, opc[3'($urandom_range(0, 5))]);
        repeat ($urandom_range(0, 3)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        push_item(1'b1, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_phase(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) random_sequence();
  endtask

  // Wait for every item taken and every result checked, then let any
  // result-less work drain. A half-built frame is finished with filler bytes
  // so opcode registers never change under one.
  task automatic settle();
    do begin
      while (items_taken != items_sent || led_actions_due.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (frm_cnt != 0) begin
        for (int i = frm_cnt; i < frm_len; i++) push_item(1'b0, 8'h00);
      end
    end while (items_taken != items_sent);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    opc[REG_GO]    = OP_GO_RESET;
    opc[REG_FADE]  = OP_FADE_RESET;
    opc[REG_WRITE] = OP_WRITE_RESET;
    opc[REG_PLAY]  = OP_PLAY_RESET;
    opc[REG_STOP]  = OP_STOP_RESET;
    opc[REG_BOOT]  = OP_BOOT_RESET;
    frm        = '0;
    frm_cnt    = 0;
    frm_len    = 0;
    playing    = 1'b0;
    last_ln    = 0;
    play_pos   = 0;
    rpt_target = 8'd0;
    rpt_done   = 8'd0;
    for (int i = 0; i < DEPTH; i++) script[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset opcodes: go at level extremes, fade, boot mode
    push_item(1'b0, opc[REG_GO]);
    push_item(1'b0, 8'd0);
    push_item(1'b0, 8'd255);
    push_item(1'b0, 8'd0);
    push_item(1'b0, opc[REG_FADE]);
    push_item(1'b0, 8'd255);
    push_item(1'b0, 8'd0);
    push_item(1'b0, 8'd170);
    push_item(1'b0, opc[REG_BOOT]);
    push_item(1'b0, 8'd255);
    repeat (4) push_item(1'b0, 8'd85);
    // unknown first bytes are dropped
    push_item(1'b0, 8'd0);
    push_item(1'b0, 8'd255);
    // tick while stopped, then stop while stopped
    push_item(1'b1, 8'd0);
    push_item(1'b0, opc[REG_STOP]);
    // write line to an index past the store: ignored
    push_item(1'b0, opc[REG_WRITE]);
    push_item(1'b0, 8'd0);
    push_item(1'b0, 8'd16);
    push_item(1'b0, 8'd0);
    push_item(1'b0, opc[REG_GO]);
    push_item(1'b0, 8'd1);
    push_item(1'b0, 8'd2);
    push_item(1'b0, 8'd3);
    settle();

    random_phase(RANDOM_ITEMS);
    settle();

    // opcodes at the byte extremes
    write_opcode(REG_GO, 8'd0);
    write_opcode(REG_FADE, 8'd255);
    write_opcode(REG_WRITE, 8'd1);
    write_opcode(REG_PLAY, 8'd254);
    write_opcode(REG_STOP, 8'd128);
    write_opcode(REG_BOOT, 8'd127);
    random_phase(RANDOM_ITEMS);
    settle();

    // equal opcodes: fade hidden behind go, play hidden behind write line
    write_opcode(REG_GO, 8'd7);
    write_opcode(REG_FADE, 8'd7);
    write_opcode(REG_WRITE, 8'd9);
    write_opcode(REG_PLAY, 8'd9);
    write_opcode(REG_STOP, 8'd255);
    write_opcode(REG_BOOT, 8'd0);
    random_phase(RANDOM_ITEMS);
    settle();

    // random opcodes
    write_opcode(REG_GO, 8'($urandom_range(0, 255)));
    write_opcode(REG_FADE, 8'($urandom_range(0, 255)));
    write_opcode(REG_WRITE, 8'($urandom_range(0, 255)));
    write_opcode(REG_PLAY, 8'($urandom_range(0, 255)));
    write_opcode(REG_STOP, 8'($urandom_range(0, 255)));
    write_opcode(REG_BOOT, 8'($urandom_range(0, 255)));
    random_phase(RANDOM_ITEMS);
    settle();

    // back to the reset opcodes
    write_opcode(REG_GO, OP_GO_RESET);
    write_opcode(REG_FADE, OP_FADE_RESET);
    write_opcode(REG_WRITE, OP_WRITE_RESET);
    write_opcode(REG_PLAY, OP_PLAY_RESET);
    write_opcode(REG_STOP, OP_STOP_RESET);
    write_opcode(REG_BOOT, OP_BOOT_RESET);
    random_phase(RANDOM_ITEMS);
    settle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
